// ===== src/pbr_pkg.sv =====
`default_nettype none

package pbr_pkg;

	localparam int POS_W   = 13;
	localparam int CNT_W   = 8;
	localparam int MAX_RES = 6;
	localparam int RES_W   = 3;

	localparam logic [CNT_W-1:0] MAX_GROUP   = 8'd128;
	localparam logic [CNT_W-1:0] LITERAL_MAX = 8'd128;
	localparam logic [CNT_W-1:0] RUN_MIN     = 8'd3;
	localparam logic [CNT_W:0]   RUN_BASE    = 9'd257;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       row_end;
	} raw_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [POS_W-1:0] out_offset;
		logic             last_of_item;
		logic             row_done;
		logic [POS_W-1:0] row_bytes;
	} enc_t;

	typedef struct packed {
		logic [7:0]       group_value;
		logic [CNT_W-1:0] group_count;
		logic [CNT_W-1:0] literal_count;
		logic [POS_W-1:0] literal_header_slot;
		logic [POS_W-1:0] write_position;
	} state_t;

	typedef struct packed {
		logic [7:0]       code_byte;
		logic [POS_W-1:0] offset;
	} code_t;

	typedef code_t [3:0]         code_list_t;
	typedef code_t [MAX_RES-1:0] code_bundle_t;
	typedef enc_t  [MAX_RES-1:0] enc_bundle_t;

endpackage

`default_nettype wire

// ===== src/packbits_row_encoder_unit.sv =====
`default_nettype none

// channel | direction | payload          | handshake
// raw     | in        | pbr_pkg::raw_t   | raw_valid / raw_stall
// enc     | out       | pbr_pkg::enc_t   | enc_valid / enc_stall
//
// Each accepted raw byte is fully encoded in its cycle of acceptance and its
// zero to six requests load a six-entry bundle register, which drains one
// request per cycle from its head while enc_stall is low, the first in the
// cycle after acceptance. Bytes yielding zero or one request follow back to
// back while enc_stall is low; one yielding more stalls the raw side until
// its bundle drains. Reset clears the encoder state and empties the bundle.
module packbits_row_encoder_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         raw_valid,
	output logic              raw_stall,
	input  wire pbr_pkg::raw_t raw_data,
	output logic              enc_valid,
	input  wire logic         enc_stall,
	output pbr_pkg::enc_t     enc_data
);

	// Encoder state
	pbr_pkg::state_t st_q;

	// Bundle of pending requests, head at entry zero
	pbr_pkg::enc_bundle_t         bun_q;
	logic [pbr_pkg::RES_W-1:0]    bun_cnt_q;

	logic raw_acc;
	logic enc_take;

	pbr_pkg::state_t      st_a;
	pbr_pkg::state_t      st_g;
	pbr_pkg::state_t      st_b;
	pbr_pkg::state_t      st_next;
	pbr_pkg::code_list_t  codes_a;
	pbr_pkg::code_list_t  codes_b;
	logic [1:0]           num_a;
	logic [1:0]           num_b;
	logic                 close_a;

	pbr_pkg::enc_bundle_t      new_bun;
	logic [pbr_pkg::RES_W-1:0] new_cnt;

	assign enc_take  = enc_valid && !enc_stall;
	assign raw_acc   = raw_valid && !raw_stall;
	// Take a new byte when the bundle is empty or its last request leaves now
	assign raw_stall = !(bun_cnt_q == '0 || (bun_cnt_q == 3'd1 && !enc_stall));
	assign enc_valid = bun_cnt_q != '0;
	assign enc_data  = bun_q[0];

	// A differing byte, or a full group, closes the open group first
	assign close_a = st_q.group_count != '0 &&
		(raw_data.data_byte != st_q.group_value || st_q.group_count >= pbr_pkg::MAX_GROUP);

	pbr_close u_close_a (
		.en    (close_a),
		.cur   (st_q),
		.nxt   (st_a),
		.codes (codes_a),
		.num   (num_a)
	);

	// Open a new group or extend the current one
	always_comb begin
		st_g = st_a;
		if (st_a.group_count == '0) begin
			st_g.group_value = raw_data.data_byte;
			st_g.group_count = 8'd1;
		end else begin
			st_g.group_count = 8'(st_a.group_count + 8'd1);
		end
	end

	// At the end of a row close the group that now holds this byte
	pbr_close u_close_b (
		.en    (raw_data.row_end),
		.cur   (st_g),
		.nxt   (st_b),
		.codes (codes_b),
		.num   (num_b)
	);

	// Gather the requests in order and mark the last one
	always_comb begin
		pbr_pkg::code_bundle_t     cl;
		logic [pbr_pkg::RES_W-1:0] n;
		logic                      is_last;

		cl = '0;
		n  = '0;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) < num_a) begin
				cl[n] = codes_a[i];
				n = n + 3'd1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (2'(i) < num_b) begin
				cl[n] = codes_b[i];
				n = n + 3'd1;
			end
		end
		// close any literal still open at the end of the row
		if (raw_data.row_end && st_b.literal_count != '0) begin
			cl[n] = '{code_byte: 8'(st_b.literal_count - 8'd1),
				offset: st_b.literal_header_slot};
			n = n + 3'd1;
		end
		for (int i = 0; i < pbr_pkg::MAX_RES; i++) begin
			is_last = 3'(i) == 3'(n - 3'd1);
			new_bun[i].out_byte     = cl[i].code_byte;
			new_bun[i].out_offset   = cl[i].offset;
			new_bun[i].last_of_item = is_last;
			new_bun[i].row_done     = is_last && raw_data.row_end;
			new_bun[i].row_bytes    = (is_last && raw_data.row_end) ?
				st_b.write_position : '0;
		end
		new_cnt = n;
	end

	// A finished row returns the state to its reset values
	always_comb begin
		st_next = raw_data.row_end ? '0 : st_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			bun_cnt_q <= '0;
		end else begin
			if (raw_acc) begin
				st_q      <= st_next;
				bun_cnt_q <= new_cnt;
			end else if (enc_take) begin
				bun_cnt_q <= bun_cnt_q - 3'd1;
			end
		end
	end

	// Payload: load a fresh bundle, or advance the head on a take
	always_ff @(posedge clk) begin
		if (raw_acc) begin
			bun_q <= new_bun;
		end else if (enc_take) begin
			for (int i = 0; i < pbr_pkg::MAX_RES - 1; i++) begin
				bun_q[i] <= bun_q[i + 1];
			end
		end
	end

	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc_data.row_done |-> enc_data.last_of_item)
		else $error("row_done without last_of_item");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.group_count <= pbr_pkg::MAX_GROUP && st_q.literal_count < pbr_pkg::LITERAL_MAX)
		else $error("group or literal count out of range");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		raw_acc && raw_data.row_end |=>
			st_q.group_count == '0 && st_q.literal_count == '0 && st_q.write_position == '0)
		else $error("state not cleared after end of row");

	a_row_end_results: assert property (@(posedge clk) disable iff (!arst_n)
		raw_acc && raw_data.row_end |=> bun_cnt_q != '0)
		else $error("end of row produced no request");

	a_bundle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bun_cnt_q <= 3'(pbr_pkg::MAX_RES))
		else $error("bundle count out of range");

endmodule

`default_nettype wire

// ===== src/pbr_close.sv =====
`default_nettype none

// Close the open group: emit a run, or append the bytes to the literal.
module pbr_close (
	input  wire logic             en,
	input  wire pbr_pkg::state_t  cur,
	output pbr_pkg::state_t       nxt,
	output pbr_pkg::code_list_t   codes,
	output logic [1:0]            num
);

	always_comb begin
		logic [pbr_pkg::CNT_W:0]   lsum;
		logic [pbr_pkg::CNT_W-1:0] lc;
		logic [pbr_pkg::POS_W-1:0] wp;
		logic [pbr_pkg::POS_W-1:0] slot;
		logic [1:0]                n;

		nxt   = cur;
		codes = '0;
		n     = 2'd0;
		lc    = cur.literal_count;
		wp    = cur.write_position;
		slot  = cur.literal_header_slot;
		lsum  = {1'b0, cur.literal_count} + {1'b0, cur.group_count};

		if (en && cur.group_count != '0) begin
			if (cur.group_count >= pbr_pkg::RUN_MIN) begin
				if (lc != '0) begin
					codes[n] = '{code_byte: 8'(lc - 8'd1), offset: slot};
					n = n + 2'd1;
				end
				codes[n] = '{code_byte: 8'(pbr_pkg::RUN_BASE - {1'b0, cur.group_count}),
					offset: wp};
				n = n + 2'd1;
				codes[n] = '{code_byte: cur.group_value, offset: 13'(wp + 13'd1)};
				n = n + 2'd1;
				wp = 13'(wp + 13'd2);
				lc = '0;
			end else begin
				if (lsum > {1'b0, pbr_pkg::LITERAL_MAX}) begin
					codes[n] = '{code_byte: 8'(lc - 8'd1), offset: slot};
					n = n + 2'd1;
					lc = '0;
				end
				// reserve the header slot of a fresh literal
				if (lc == '0) begin
					slot = wp;
					wp   = 13'(wp + 13'd1);
				end
				codes[n] = '{code_byte: cur.group_value, offset: wp};
				n = n + 2'd1;
				wp = 13'(wp + 13'd1);
				if (cur.group_count == 8'd2) begin
					codes[n] = '{code_byte: cur.group_value, offset: wp};
					n = n + 2'd1;
					wp = 13'(wp + 13'd1);
				end
				lc = 8'(lc + cur.group_count);
				if (lc == pbr_pkg::LITERAL_MAX) begin
					codes[n] = '{code_byte: 8'(pbr_pkg::LITERAL_MAX - 8'd1), offset: slot};
					n = n + 2'd1;
					lc = '0;
				end
			end
			nxt.group_count         = '0;
			nxt.literal_count       = lc;
			nxt.write_position      = wp;
			nxt.literal_header_slot = slot;
		end
		num = n;
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic raw_valid = 1'b0;
	logic raw_stall;
	pbr_pkg::raw_t raw_data = '0;
	logic enc_valid;
	logic enc_stall = 1'b0;
	pbr_pkg::enc_t enc_data;

	// quiet = 1 suspends idling on both sides
	bit quiet = 1'b0;
	int unsigned raw_sent = 0;
	int unsigned mismatches = 0;

	// encoder state as seen by the predictor, and the bytes still owed by the block
	pbr_pkg::state_t pack_st = '0;
	pbr_pkg::enc_t codes_now[$];
	pbr_pkg::enc_t codes_due[$];

	packbits_row_encoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_data  (raw_data),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor: PackBits encoding of one raw byte
	// ---------------------------------------------------------------

	// Queue one encoded byte for the current input; at most MAX_RES per input.
	task automatic emit_code(input logic [7:0] b, input logic [pbr_pkg::POS_W-1:0] off);
		pbr_pkg::enc_t e;
		if (codes_now.size() < pbr_pkg::MAX_RES) begin
			e = '0;
			e.out_byte = b;
			e.out_offset = off;
			codes_now.push_back(e);
		end
	endtask

	// Close the open literal: its header goes into the slot reserved on opening.
	task automatic flush_literal();
		if (pack_st.literal_count != 0) begin
			emit_code(pack_st.literal_count - 8'd1, pack_st.literal_header_slot);
			pack_st.literal_count = '0;
		end
	endtask

	task automatic put_byte(input logic [7:0] b);
		emit_code(b, pack_st.write_position);
		pack_st.write_position = pack_st.write_position + 1'b1;
	endtask

	// Close the open group, either as a run or by adding it to the literal.
	task automatic flush_group();
		int unsigned c;
		c = pack_st.group_count;
		if (c != 0) begin
			if (c >= pbr_pkg::RUN_MIN) begin
				flush_literal();
				put_byte(8'(pbr_pkg::RUN_BASE - c));
				put_byte(pack_st.group_value);
			end else begin
				// a pair must not push the literal past its limit
				if (pack_st.literal_count + c > pbr_pkg::LITERAL_MAX)
					flush_literal();
				if (pack_st.literal_count == 0) begin
					pack_st.literal_header_slot = pack_st.write_position;
					pack_st.write_position = pack_st.write_position + 1'b1;
				end
				for (int k = 0; k < c; k++)
					put_byte(pack_st.group_value);
				pack_st.literal_count = pack_st.literal_count + 8'(c);
				if (pack_st.literal_count == pbr_pkg::LITERAL_MAX)
					flush_literal();
			end
			pack_st.group_count = '0;
		end
	endtask

	// Work out the encoded bytes owed for one accepted raw request.
	task automatic pack_byte(input pbr_pkg::raw_t r);
		int n;
		codes_now.delete();
		if (pack_st.group_count != 0 && (r.data_byte != pack_st.group_value ||
				pack_st.group_count >= pbr_pkg::MAX_GROUP))
			flush_group();
		if (pack_st.group_count == 0) begin
			pack_st.group_value = r.data_byte;
			pack_st.group_count = 8'd1;
		end else begin
			pack_st.group_count = pack_st.group_count + 8'd1;
		end
		n = codes_now.size();
		if (r.row_end) begin
			flush_group();
			flush_literal();
			n = codes_now.size();
			if (n > 0) begin
				codes_now[n-1].row_done = 1'b1;
				codes_now[n-1].row_bytes = pack_st.write_position;
			end
			// the row is finished: start the next one from scratch
			pack_st = '0;
		end
		if (n > 0)
			codes_now[n-1].last_of_item = 1'b1;
		foreach (codes_now[i])
			codes_due.push_back(codes_now[i]);
	endtask

	// ---------------------------------------------------------------
	// Raw side
	// ---------------------------------------------------------------

	// Offer one raw request and hold it until accepted; valid stays high
	// afterwards so that back-to-back requests need no bubble.
	task automatic send_raw(input logic [7:0] b, input logic last);
		pbr_pkg::raw_t r;
		r.data_byte = b;
		r.row_end = last;
		while (!quiet && $urandom_range(0, 99) < 28) begin
			raw_valid <= 1'b0;
			@(posedge clk);
		end
		raw_valid <= 1'b1;
		raw_data <= r;
		@(posedge clk);
		while (raw_stall !== 1'b0)
			@(posedge clk);
		pack_byte(r);
		raw_sent++;
	endtask

	task automatic send_run(input logic [7:0] v, input int n, input logic ends_row);
		for (int i = 0; i < n; i++)
			send_raw(v, ends_row && (i == n - 1));
	endtask

	function automatic logic [7:0] pick_other(input logic [7:0] prev);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == prev)
			v = v + 8'd1;
		return v;
	endfunction

	// One short row made of singles, pairs and short runs.
	task automatic send_random_row();
		int target;
		int left;
		int len;
		int kind;
		logic [7:0] v;
		target = $urandom_range(1, 10);
		left = target;
		while (left > 0) begin
			kind = $urandom_range(0, 99);
			if (kind < 40)
				len = 1;
			else if (kind < 65)
				len = 2;
			else
				len = $urandom_range(3, 6);
			if (len > left)
				len = left;
			// a narrow alphabet makes neighbouring groups merge by chance
			v = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) :
				8'($urandom_range(0, 255));
			send_run(v, len, len == left);
			left -= len;
		end
	endtask

	// ---------------------------------------------------------------
	// Encoded side: stall at random, check every accepted request
	// ---------------------------------------------------------------

	task automatic log_mismatch(input bit have_want, input pbr_pkg::enc_t want,
			input pbr_pkg::enc_t got);
		if (mismatches < 10) begin
			if (have_want)
				$display("%0t enc mismatch: exp byte=%02h off=%0d last=%0b done=%0b len=%0d,",
					$realtime, want.out_byte, want.out_offset, want.last_of_item,
					want.row_done, want.row_bytes,
					" got byte=%02h off=%0d last=%0b done=%0b len=%0d",
					got.out_byte, got.out_offset, got.last_of_item,
					got.row_done, got.row_bytes);
			else
				$display("%0t enc request with nothing owed:",
					$realtime,
					" byte=%02h off=%0d last=%0b done=%0b len=%0d",
					got.out_byte, got.out_offset, got.last_of_item,
					got.row_done, got.row_bytes);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin : enc_check
		pbr_pkg::enc_t want;
		if (arst_n && enc_valid === 1'b1 && enc_stall == 1'b0) begin
			if (codes_due.size() == 0) begin
				log_mismatch(1'b0, '0, enc_data);
			end else begin
				want = codes_due.pop_front();
				if (enc_data.out_byte !== want.out_byte ||
						enc_data.out_offset !== want.out_offset ||
						enc_data.last_of_item !== want.last_of_item ||
						enc_data.row_done !== want.row_done ||
						enc_data.row_bytes !== want.row_bytes)
					log_mismatch(1'b1, want, enc_data);
			end
		end
		enc_stall <= !quiet && ($urandom_range(0, 99) < 28);
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Short rows: field extremes, lone bytes, a pair, the shortest run,
	// a literal closed by a run, and a row end that changes value or
	// completes a run.
	task automatic test_directed();
		send_raw(8'h00, 1'b1);
		send_raw(8'hFF, 1'b1);
		send_run(8'h55, 2, 1'b1);
		send_run(8'hAA, 3, 1'b1);
		send_raw(8'h01, 1'b0);
		send_raw(8'h02, 1'b0);
		send_run(8'h07, 3, 1'b0);
		send_raw(8'h03, 1'b1);
		send_run(8'h10, 4, 1'b0);
		send_raw(8'h11, 1'b1);
		send_run(8'h22, 3, 1'b1);
	endtask

	// Long stretch with neither side idling: 127 lone bytes, then a pair
	// that would push the literal past 128 bytes and so closes it first.
	task automatic test_literal_cap();
		logic [7:0] v;
		quiet = 1'b1;
		v = 8'h00;
		for (int i = 0; i < 127; i++) begin
			v = pick_other(v);
			send_raw(v, 1'b0);
		end
		v = pick_other(v);
		send_run(v, 2, 1'b1);
		quiet = 1'b0;
	endtask

	task automatic test_random_rows();
		int unsigned start;
		start = raw_sent;
		while (raw_sent - start < 25)
			send_random_row();
	endtask

	initial begin
		int guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_literal_cap();
		test_random_rows();

		// drop valid, let the bundle drain, then hold for stray requests
		raw_valid <= 1'b0;
		guard = 0;
		while (codes_due.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);

		if (mismatches == 0 && codes_due.size() == 0) begin
			$display("[packbits_row_encoder_unit] OK");
		end else begin
			$display("[packbits_row_encoder_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[packbits_row_encoder_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
